@@ hw/rtl/utf8_text_validator_unit_macros.svh @@
// Assertion helpers for the validator RTL.
`ifndef UTF8_TEXT_VALIDATOR_UNIT_MACROS_SVH
`define UTF8_TEXT_VALIDATOR_UNIT_MACROS_SVH

// Same-cycle implication, checked on every rising edge out of reset.
`define UTV_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define UTV_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ hw/rtl/utv_pkg.sv @@
package utv_pkg;

    localparam logic [16:0] COUNT_CAP        = 17'd65536;
    localparam logic [15:0] LENGTH_LIMIT_MAX = 16'd65535;
    localparam logic [15:0] MAX_LENGTH_RST   = 16'd64;

    // check_mode codes; code 3 behaves as plain
    localparam logic [1:0] MODE_PLAIN = 2'd0;
    localparam logic [1:0] MODE_IDENT = 2'd1;
    localparam logic [1:0] MODE_AGENT = 2'd2;

    // configuration register indexes
    localparam logic CFG_CHECK_MODE = 1'b0;
    localparam logic CFG_MAX_LENGTH = 1'b1;

    typedef enum logic [2:0] {
        ERR_OK      = 3'd0,
        ERR_EMPTY   = 3'd1,
        ERR_LENGTH  = 3'd2,
        ERR_ENCODE  = 3'd3,
        ERR_CONTROL = 3'd4
    } t_err_kind;

    // special rule for the first continuation byte after a lead byte
    typedef enum logic [2:0] {
        RULE_NONE = 3'd0,
        RULE_E0   = 3'd1,
        RULE_ED   = 3'd2,
        RULE_F0   = 3'd3,
        RULE_F4   = 3'd4
    } t_rule;

    typedef struct packed {
        logic [1:0]  cont_left;
        t_rule       rule;
        logic        enc_bad;
        logic        ctl_bad;
        logic [16:0] total;
    } t_str_state;

    typedef struct packed {
        logic [7:0] text_byte;
        logic       end_marker;
    } t_in_item;

    typedef struct packed {
        logic        is_valid;
        t_err_kind   error_kind;
        logic [16:0] length_seen;
    } t_out_item;

endpackage

@@ hw/rtl/utf8_text_validator_unit.sv @@
// Strict UTF-8 string checker. Bytes of a string arrive one per input
// transaction with end_marker low; a transaction with end_marker high closes
// the string and produces exactly one result transaction (verdict, error kind,
// saturating byte count). Byte transactions produce no result. Throughput is
// one transaction per clock while o_in_stall is low: each transaction passes
// through the input register, where the per-byte decode or the verdict logic
// runs, and a verdict then sits in the output register until taken. Result
// valid rises in the cycle after the end transaction leaves the input register.
// Input stall rises only when an end transaction waits in the input register
// behind an untaken result. check_mode and max_length are written through the
// plain write port and must only change while no string transaction is in
// flight; they persist across strings.
`include "utf8_text_validator_unit_macros.svh"

module utf8_text_validator_unit import utv_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,

    // configuration write port
    input  logic        i_cfg_we,
    input  logic        i_cfg_index,
    input  logic [15:0] i_cfg_data,

    // byte stream in
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  t_in_item    i_in_item,

    // verdicts out
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output t_out_item   o_out_item
);

    // configuration
    logic [1:0]  r_mode;
    logic [15:0] r_max_len;

    // input register
    logic        r_in_valid;
    t_in_item    r_in;

    // string state and output register
    t_str_state  r_str;
    t_str_state  n_str;
    t_str_state  step_st;
    logic        r_out_valid;
    t_out_item   r_out;
    t_out_item   verdict;

    logic        out_free;
    logic        s_adv;     // registered transaction is consumed this cycle

    // output slot can take a new verdict if empty or draining now
    assign out_free   = !r_out_valid || !i_out_stall;
    // byte transactions never need the output slot
    assign s_adv      = r_in_valid && (!r_in.end_marker || out_free);
    assign o_in_stall = r_in_valid && !s_adv;

    utv_step u_step (
        .i_st   (r_str),
        .i_byte (r_in.text_byte),
        .i_mode (r_mode),
        .o_st   (step_st)
    );

    utv_verdict u_verdict (
        .i_st      (r_str),
        .i_mode    (r_mode),
        .i_max_len (r_max_len),
        .o_item    (verdict)
    );

    // the end transaction clears the string state for the next string
    assign n_str = r_in.end_marker ? '0 : step_st;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode    <= MODE_PLAIN;
            r_max_len <= MAX_LENGTH_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_CHECK_MODE: r_mode    <= i_cfg_data[1:0];
                CFG_MAX_LENGTH: r_max_len <= i_cfg_data;
                default:        r_mode    <= r_mode;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_str       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (!o_in_stall) begin
                r_in_valid <= i_in_valid;
            end
            if (s_adv) begin
                r_str <= n_str;
            end
            if (s_adv && r_in.end_marker) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (!o_in_stall) begin
            r_in <= i_in_item;
        end
        if (s_adv && r_in.end_marker) begin
            r_out <= verdict;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;

    `UTV_ASSERT_NOW(a_verdict_consistent, o_out_valid,
        o_out_item.is_valid == (o_out_item.error_kind == ERR_OK),
        "verdict flag disagrees with error kind")

    `UTV_ASSERT_NEXT(a_end_clears_string, s_adv && r_in.end_marker,
        r_str.total == 17'd0 && r_str.cont_left == 2'd0 && !r_str.enc_bad,
        "string state not cleared after end transaction")

    `UTV_ASSERT_NEXT(a_end_gives_result, s_adv && r_in.end_marker,
        o_out_valid,
        "end transaction consumed without a result")

endmodule

@@ hw/rtl/utv_step.sv @@
// Per-byte update: UTF-8 decoder, control byte rules, saturating count.
module utv_step import utv_pkg::*; (
    input  t_str_state i_st,
    input  logic [7:0] i_byte,
    input  logic [1:0] i_mode,
    output t_str_state o_st
);

    logic cont_ok;

    always_comb begin
        if (i_byte[7:6] != 2'b10) begin
            cont_ok = 1'b0;
        end else begin
            unique case (i_st.rule)
                RULE_E0: cont_ok = (i_byte >= 8'ha0);
                RULE_ED: cont_ok = (i_byte <  8'ha0);
                RULE_F0: cont_ok = (i_byte >= 8'h90);
                RULE_F4: cont_ok = (i_byte <  8'h90);
                default: cont_ok = 1'b1;
            endcase
        end
    end

    always_comb begin
        o_st = i_st;
        if (i_st.total < COUNT_CAP) begin
            o_st.total = i_st.total + 17'd1;
        end

        if (i_st.cont_left != 2'd0) begin
            o_st.rule = RULE_NONE;
            if (cont_ok) begin
                o_st.cont_left = i_st.cont_left - 2'd1;
            end else begin
                // broken sequence: flag it and drop the rest
                o_st.enc_bad   = 1'b1;
                o_st.cont_left = 2'd0;
            end
        end else begin
            priority if (i_byte == 8'h00) begin
                o_st.enc_bad = 1'b1;
            end else if (i_byte < 8'h80) begin
                o_st.cont_left = 2'd0;
            end else if (i_byte >= 8'hc2 && i_byte <= 8'hdf) begin
                o_st.cont_left = 2'd1;
            end else if (i_byte >= 8'he0 && i_byte <= 8'hef) begin
                o_st.cont_left = 2'd2;
                o_st.rule = (i_byte == 8'he0) ? RULE_E0 :
                            (i_byte == 8'hed) ? RULE_ED : RULE_NONE;
            end else if (i_byte >= 8'hf0 && i_byte <= 8'hf4) begin
                o_st.cont_left = 2'd3;
                o_st.rule = (i_byte == 8'hf0) ? RULE_F0 :
                            (i_byte == 8'hf4) ? RULE_F4 : RULE_NONE;
            end else begin
                o_st.enc_bad = 1'b1;
            end
        end

        unique case (i_mode)
            MODE_IDENT: begin
                if (i_byte < 8'h20 || i_byte == 8'h7f) begin
                    o_st.ctl_bad = 1'b1;
                end
            end
            MODE_AGENT: begin
                if (i_byte < 8'h20 && i_byte != 8'h0a) begin
                    o_st.ctl_bad = 1'b1;
                end
            end
            default: begin
                o_st.ctl_bad = i_st.ctl_bad;
            end
        endcase
    end

endmodule

@@ hw/rtl/utv_verdict.sv @@
// End-of-string verdict, priority empty, length (both only in ident and agent modes), encoding, control.
module utv_verdict import utv_pkg::*; (
    input  t_str_state  i_st,
    input  logic [1:0]  i_mode,
    input  logic [15:0] i_max_len,
    output t_out_item   o_item
);

    logic        strict;
    logic        enc_bad;
    logic [15:0] limit;

    always_comb begin
        strict  = (i_mode == MODE_IDENT) || (i_mode == MODE_AGENT);
        // an unfinished sequence at the end is an encoding error
        enc_bad = i_st.enc_bad || (i_st.cont_left != 2'd0);
        limit   = (i_max_len < LENGTH_LIMIT_MAX) ? i_max_len : LENGTH_LIMIT_MAX;

        priority if (strict && i_st.total == 17'd0) begin
            o_item.error_kind = ERR_EMPTY;
        end else if (strict && i_st.total > {1'b0, limit}) begin
            o_item.error_kind = ERR_LENGTH;
        end else if (enc_bad) begin
            o_item.error_kind = ERR_ENCODE;
        end else if (i_st.ctl_bad) begin
            o_item.error_kind = ERR_CONTROL;
        end else begin
            o_item.error_kind = ERR_OK;
        end

        o_item.is_valid    = (o_item.error_kind == ERR_OK);
        o_item.length_seen = i_st.total;
    end

endmodule
